FILE: hdl/i4bp_pkg.sv
// Shared types, codes and the sample-selection table of the 4x4 intra predictor.
package i4bp_pkg;

	localparam int SAMPLE_W = 14;
	localparam int NUM_EDGE = 13;	// L3 L2 L1 L0 C T0..T7
	localparam int NUM_F2   = 12;
	localparam int EDGE_C   = 4;	// corner position in the edge vector

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef sample_t [NUM_EDGE-1:0] edge_vec_t;
	typedef sample_t [NUM_F2-1:0] f2_vec_t;
	typedef sample_t [3:0] row_t;

	localparam logic [3:0] MODE_VERT = 4'd0;
	localparam logic [3:0] MODE_HOR  = 4'd1;
	localparam logic [3:0] MODE_DC   = 4'd2;
	localparam logic [3:0] MODE_DL   = 4'd3;
	localparam logic [3:0] MODE_DR   = 4'd4;
	localparam logic [3:0] MODE_VR   = 4'd5;
	localparam logic [3:0] MODE_HD   = 4'd6;
	localparam logic [3:0] MODE_VL   = 4'd7;
	localparam logic [3:0] MODE_HU   = 4'd8;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_NOT_ALLOWED = 2'd1;
	localparam logic [1:0] ST_ILLEGAL     = 2'd2;

	localparam logic [2:0] ADDR_BIT_DEPTH = 3'd0;
	localparam logic [3:0] BIT_DEPTH_RST  = 4'd8;
	localparam logic [3:0] BIT_DEPTH_MIN  = 4'd8;
	localparam logic [3:0] BIT_DEPTH_MAX  = 4'd14;

	typedef enum logic [1:0] {
		PK_RAW,
		PK_F2,
		PK_F3
	} pick_kind_t;

	typedef struct packed {
		pick_kind_t  kind;
		logic [3:0]  idx;
	} pick_t;

	// Which edge sample or filter tap feeds position (x, y) for a given mode.
	// f2[k] = (e[k]+e[k+1]+1)>>1, f3[k] is the 3-tap filter centered on e[k].
	function automatic pick_t pred_pick(input logic [3:0] mode, input logic [1:0] xc,
			input logic [1:0] yc);
		int x;
		int y;
		int z;
		int h;
		pick_t p;
		x = int'(xc);
		y = int'(yc);
		p.kind = PK_RAW;
		p.idx = '0;
		unique case (mode)
			MODE_VERT: begin
				p.idx = 4'(5 + x);
			end
			MODE_HOR: begin
				p.idx = 4'(3 - y);
			end
			MODE_DL: begin
				p.kind = PK_F3;
				p.idx = 4'(6 + x + y);	// bottom-right clamps at T7
			end
			MODE_DR: begin
				p.kind = PK_F3;
				p.idx = 4'(4 + x - y);
			end
			MODE_VR: begin
				z = 2 * x - y;
				h = x - (y >> 1);
				if (z >= 0 && (z % 2) == 0) begin
					p.kind = PK_F2;
					p.idx = 4'(4 + h);
				end else if (z > 0) begin
					p.kind = PK_F3;
					p.idx = 4'(4 + h);
				end else if (z == -1) begin
					p.kind = PK_F3;
					p.idx = 4'(EDGE_C);
				end else begin
					p.kind = PK_F3;
					p.idx = 4'(5 - y);
				end
			end
			MODE_HD: begin
				z = 2 * y - x;
				h = y - (x >> 1);
				if (z >= 0 && (z % 2) == 0) begin
					p.kind = PK_F2;
					p.idx = 4'(3 - h);
				end else if (z > 0) begin
					p.kind = PK_F3;
					p.idx = 4'(4 - h);
				end else if (z == -1) begin
					p.kind = PK_F3;
					p.idx = 4'(EDGE_C);
				end else begin
					p.kind = PK_F3;
					p.idx = 4'(3 + x);
				end
			end
			MODE_VL: begin
				h = x + (y >> 1);
				if ((y % 2) == 0) begin
					p.kind = PK_F2;
					p.idx = 4'(5 + h);
				end else begin
					p.kind = PK_F3;
					p.idx = 4'(6 + h);
				end
			end
			MODE_HU: begin
				z = x + 2 * y;
				h = y + (x >> 1);
				if (z == 0 || z == 2 || z == 4) begin
					p.kind = PK_F2;
					p.idx = 4'(2 - h);
				end else if (z == 1 || z == 3) begin
					p.kind = PK_F3;
					p.idx = 4'(2 - h);
				end else if (z == 5) begin
					p.kind = PK_F3;	// clamped below L3
					p.idx = 4'd0;
				end else begin
					p.idx = 4'd0;	// plain L3
				end
			end
			default: begin
				p.idx = '0;
			end
		endcase
		return p;
	endfunction

endpackage

FILE: hdl/i4bp_filt.sv
// Shared 2-tap and 3-tap rounding filter bank over the 13-sample edge.
module i4bp_filt (
	input  i4bp_pkg::edge_vec_t edge_smp,
	output i4bp_pkg::f2_vec_t   f2,
	output i4bp_pkg::edge_vec_t f3
);
	import i4bp_pkg::*;

	for (genvar k = 0; k < NUM_F2; k++) begin : g_f2
		logic [SAMPLE_W:0] s2;
		assign s2 = {1'b0, edge_smp[k]} + {1'b0, edge_smp[k+1]} + (SAMPLE_W+1)'(1);
		assign f2[k] = s2[SAMPLE_W:1];
	end

	for (genvar k = 0; k < NUM_EDGE; k++) begin : g_f3
		sample_t a;
		sample_t c;
		logic [SAMPLE_W+1:0] s3;
		// ends repeat the outermost sample
		assign a = (k == 0) ? edge_smp[0] : edge_smp[(k == 0) ? 0 : k - 1];
		assign c = (k == NUM_EDGE - 1) ? edge_smp[NUM_EDGE-1]
			: edge_smp[(k == NUM_EDGE - 1) ? NUM_EDGE - 1 : k + 1];
		assign s3 = (SAMPLE_W+2)'(a) + {1'b0, edge_smp[k], 1'b0} + (SAMPLE_W+2)'(c)
			+ (SAMPLE_W+2)'(2);
		assign f3[k] = s3[SAMPLE_W+1:2];
	end

endmodule

FILE: hdl/i4bp_lane.sv
// One row lane: picks the four predicted samples of its row from edge and filter taps.
module i4bp_lane (
	input  logic [3:0]          mode,
	input  logic [1:0]          row_idx,
	input  i4bp_pkg::edge_vec_t edge_smp,
	input  i4bp_pkg::f2_vec_t   f2,
	input  i4bp_pkg::edge_vec_t f3,
	output i4bp_pkg::row_t      row
);
	import i4bp_pkg::*;

	for (genvar x = 0; x < 4; x++) begin : g_col
		pick_t p;
		assign p = pred_pick(mode, 2'(x), row_idx);
		always_comb begin
			unique case (p.kind)
				PK_RAW:  row[x] = edge_smp[p.idx];
				PK_F2:   row[x] = f2[p.idx];
				PK_F3:   row[x] = f3[p.idx];
				default: row[x] = '0;
			endcase
		end
	end

endmodule

FILE: hdl/intra_4x4_block_predictor.sv
// Intra 4x4 predictor top: edge build, filter bank, four row lanes, DC and output merge.
// The result register loads at the edge that accepts the request. Rate is one block
// per cycle unless m_tready stalls, set by the single registered stage after the lanes.
// s_tready is high while the result register is empty or being drained this cycle.
// Reset clears the result valid flag and sets bit_depth to 8; payload is not reset.
module intra_4x4_block_predictor (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// left_samples[55:0], top_samples[111:56], top_right_samples[167:112],
	// corner_sample[181:168], zero pad [183:182]
	input  logic [183:0] s_tdata,
	// pred_mode[3:0], avail_left[4], avail_top[5], avail_top_right[6], avail_corner[7]
	input  logic [7:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// row_0[55:0], row_1[111:56], row_2[167:112], row_3[223:168]
	output logic [223:0] m_tdata,
	// status[1:0]
	output logic [1:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import i4bp_pkg::*;

	logic [3:0]      bit_depth_q;
	logic            m_tvalid_q;
	logic [223:0]    tdata_q;
	logic [1:0]      tuser_q;

	logic [3:0]      mode;
	logic            al;
	logic            at;
	logic            atr;
	logic            ac;
	row_t            left_s;
	row_t            top_s;
	row_t            tr_s;
	edge_vec_t       edge_smp;
	f2_vec_t         f2;
	edge_vec_t       f3;
	row_t [3:0]      lane_row;
	logic [1:0]      status;
	logic [15:0]     sum_l;
	logic [15:0]     sum_t;
	logic [16:0]     sum;
	logic [16:0]     dc_both;
	logic [16:0]     dc_one;
	logic [3:0]      bd_c;
	sample_t         dc_val;
	logic [223:0]    tdata_d;

	// APB register
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_BIT_DEPTH) ? {28'd0, bit_depth_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_depth_q <= BIT_DEPTH_RST;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_BIT_DEPTH) begin
			bit_depth_q <= pwdata[3:0];
		end
	end

	// request unpack
	assign mode = s_tuser[3:0];
	assign al   = s_tuser[4];
	assign at   = s_tuser[5];
	assign atr  = s_tuser[6];
	assign ac   = s_tuser[7];
	assign left_s = s_tdata[55:0];
	assign top_s  = s_tdata[111:56];
	assign tr_s   = s_tdata[167:112];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			edge_smp[3-i] = left_s[i];
			edge_smp[5+i] = top_s[i];
			edge_smp[9+i] = atr ? tr_s[i] : top_s[3];
		end
		edge_smp[EDGE_C] = s_tdata[181:168];
	end

	i4bp_filt u_filt (
		.edge_smp (edge_smp),
		.f2       (f2),
		.f3       (f3)
	);

	for (genvar r = 0; r < 4; r++) begin : g_lane
		i4bp_lane u_lane (
			.mode     (mode),
			.row_idx  (2'(r)),
			.edge_smp (edge_smp),
			.f2       (f2),
			.f3       (f3),
			.row      (lane_row[r])
		);
	end

	always_comb begin
		priority if (mode > MODE_HU) begin
			status = ST_ILLEGAL;
		end else if ((mode == MODE_VERT || mode == MODE_DL || mode == MODE_VL) && !at) begin
			status = ST_NOT_ALLOWED;
		end else if ((mode == MODE_HOR || mode == MODE_HU) && !al) begin
			status = ST_NOT_ALLOWED;
		end else if ((mode == MODE_DR || mode == MODE_VR || mode == MODE_HD)
				&& !(al && at && ac)) begin
			status = ST_NOT_ALLOWED;
		end else begin
			status = ST_OK;
		end
	end

	// DC value
	assign sum_l = 16'(left_s[0]) + 16'(left_s[1]) + 16'(left_s[2]) + 16'(left_s[3]);
	assign sum_t = 16'(top_s[0]) + 16'(top_s[1]) + 16'(top_s[2]) + 16'(top_s[3]);
	assign sum   = (al ? 17'(sum_l) : 17'd0) + (at ? 17'(sum_t) : 17'd0);
	assign dc_both = (sum + 17'd4) >> 3;
	assign dc_one  = (sum + 17'd2) >> 2;

	always_comb begin
		priority if (bit_depth_q < BIT_DEPTH_MIN) begin
			bd_c = BIT_DEPTH_MIN;
		end else if (bit_depth_q > BIT_DEPTH_MAX) begin
			bd_c = BIT_DEPTH_MAX;
		end else begin
			bd_c = bit_depth_q;
		end
		priority if (al && at) begin
			dc_val = dc_both[SAMPLE_W-1:0];
		end else if (al || at) begin
			dc_val = dc_one[SAMPLE_W-1:0];
		end else begin
			dc_val = sample_t'(1) << (bd_c - 4'd1);	// mid-grey
		end
	end

	// merge lanes into the result word
	always_comb begin
		if (status != ST_OK) begin
			tdata_d = '0;
		end else if (mode == MODE_DC) begin
			tdata_d = {16{dc_val}};
		end else begin
			tdata_d = lane_row;
		end
	end

	assign s_tready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tdata_q <= tdata_d;
			tuser_q <= status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
		else $error("rejected request carries nonzero samples");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_NOT_ALLOWED
			|| m_tuser == ST_ILLEGAL))
		else $error("undefined status code");

	a_accept_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> m_tvalid)
		else $error("accepted request produced no result");

	a_illegal: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[3:0] > MODE_HU) |=> (m_tuser == ST_ILLEGAL))
		else $error("illegal mode not flagged");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the 4x4 intra predictor: stream requests, APB bit depth, predicted rows.
module tb_top;
	import i4bp_pkg::*;

	localparam logic [3:0] MODE_ILLEGAL_LO = 4'd9;
	localparam logic [3:0] MODE_ILLEGAL_HI = 4'd15;
	// availability masks: {corner, top_right, top, left}
	localparam logic [3:0] AV_NONE = 4'b0000;
	localparam logic [3:0] AV_L    = 4'b0001;
	localparam logic [3:0] AV_T    = 4'b0010;
	localparam logic [3:0] AV_TR   = 4'b0100;
	localparam logic [3:0] AV_C    = 4'b1000;
	localparam logic [3:0] AV_ALL  = 4'b1111;
	localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic [3:0] mode;
		row_t       left;
		row_t       top;
		row_t       top_right;
		sample_t    corner;
		logic       al;
		logic       at;
		logic       atr;
		logic       ac;
	} blk_req_t;

	typedef struct packed {
		row_t [3:0] rows;
		logic [1:0] status;
	} block_pred_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [183:0] s_tdata = '0;	// left, top, top_right, corner, zero pad
	logic [7:0]   s_tuser = '0;	// pred_mode, avail_left, avail_top, avail_top_right, avail_corner
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [223:0] m_tdata;	// row_0, row_1, row_2, row_3
	logic [1:0]   m_tuser;	// status
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	intra_4x4_block_predictor DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	block_pred_t pending_blocks[$];
	logic [3:0]  cfg_bit_depth = BIT_DEPTH_RST;
	int          gap_pct = 0;
	int          stall_pct = 0;
	int          fail_cnt = 0;
	int          quiet_cycles = 0;

	// edge samples of the request being predicted
	int nb_left[4];
	int nb_top[8];
	int nb_corner;

	initial begin
		forever #2 clk = ~clk;
	end

	// ---------------- prediction ----------------
	function automatic int neighbor(input int x, input int y);
		if (y < 0)
			return (x < 0) ? nb_corner : nb_top[x & 7];
		if (y > 3)
			y = 3;
		return nb_left[y & 3];
	endfunction

	function automatic int avg2(input int a, input int b);
		return (a + b + 1) >> 1;
	endfunction

	function automatic int avg3(input int a, input int b, input int c);
		return (a + 2 * b + c + 2) >> 2;
	endfunction

	function automatic int directional_sample(input logic [3:0] mode, input int x, input int y);
		int z;
		int h;
		case (mode)
			MODE_VERT: return nb_top[x];
			MODE_HOR:  return nb_left[y];
			MODE_DL: begin
				if (x == 3 && y == 3)
					return (nb_top[6] + 3 * nb_top[7] + 2) >> 2;
				return avg3(nb_top[x + y], nb_top[x + y + 1], nb_top[x + y + 2]);
			end
			MODE_DR: begin
				if (x > y)
					return avg3(neighbor(x - y - 2, -1), neighbor(x - y - 1, -1),
						neighbor(x - y, -1));
				if (x < y)
					return avg3(neighbor(-1, y - x - 2), neighbor(-1, y - x - 1),
						neighbor(-1, y - x));
				return avg3(neighbor(0, -1), nb_corner, neighbor(-1, 0));
			end
			MODE_VR: begin
				z = 2 * x - y;
				h = x - (y >> 1);
				if (z >= 0 && (z & 1) == 0)
					return avg2(neighbor(h - 1, -1), neighbor(h, -1));
				if (z > 0)
					return avg3(neighbor(h - 2, -1), neighbor(h - 1, -1), neighbor(h, -1));
				if (z == -1)
					return avg3(neighbor(-1, 0), nb_corner, neighbor(0, -1));
				return avg3(neighbor(-1, y - 1), neighbor(-1, y - 2), neighbor(-1, y - 3));
			end
			MODE_HD: begin
				z = 2 * y - x;
				h = y - (x >> 1);
				if (z >= 0 && (z & 1) == 0)
					return avg2(neighbor(-1, h - 1), neighbor(-1, h));
				if (z > 0)
					return avg3(neighbor(-1, h - 2), neighbor(-1, h - 1), neighbor(-1, h));
				if (z == -1)
					return avg3(neighbor(-1, 0), nb_corner, neighbor(0, -1));
				return avg3(neighbor(x - 1, -1), neighbor(x - 2, -1), neighbor(x - 3, -1));
			end
			MODE_VL: begin
				h = x + (y >> 1);
				if ((y & 1) == 0)
					return avg2(nb_top[h], nb_top[h + 1]);
				return avg3(nb_top[h], nb_top[h + 1], nb_top[h + 2]);
			end
			MODE_HU: begin
				z = x + 2 * y;
				h = y + (x >> 1);
				if (z == 0 || z == 2 || z == 4)
					return avg2(neighbor(-1, h), neighbor(-1, h + 1));
				if (z == 1 || z == 3)
					return avg3(neighbor(-1, h), neighbor(-1, h + 1), neighbor(-1, h + 2));
				if (z == 5)
					return (nb_left[2] + 3 * nb_left[3] + 2) >> 2;
				return nb_left[3];
			end
			default: return 0;
		endcase
	endfunction

	function automatic block_pred_t predict_block(input blk_req_t r, input logic [3:0] bd_reg);
		block_pred_t p;
		int i;
		int x;
		int y;
		int sum;
		int dc;
		int bd;
		p = '0;
		for (i = 0; i < 4; i++) begin
			nb_left[i] = int'(r.left[i]);
			nb_top[i] = int'(r.top[i]);
			// missing top-right repeats the last top sample
			nb_top[4 + i] = r.atr ? int'(r.top_right[i]) : int'(r.top[3]);
		end
		nb_corner = int'(r.corner);

		if (r.mode > MODE_HU)
			p.status = ST_ILLEGAL;
		else if ((r.mode == MODE_VERT || r.mode == MODE_DL || r.mode == MODE_VL) && !r.at)
			p.status = ST_NOT_ALLOWED;
		else if ((r.mode == MODE_HOR || r.mode == MODE_HU) && !r.al)
			p.status = ST_NOT_ALLOWED;
		else if ((r.mode == MODE_DR || r.mode == MODE_VR || r.mode == MODE_HD) &&
				!(r.al && r.at && r.ac))
			p.status = ST_NOT_ALLOWED;
		else
			p.status = ST_OK;
		if (p.status != ST_OK)
			return p;

		if (r.mode == MODE_DC) begin
			sum = 0;
			for (i = 0; i < 4; i++)
				sum += (r.al ? nb_left[i] : 0) + (r.at ? nb_top[i] : 0);
			bd = (bd_reg < BIT_DEPTH_MIN) ? BIT_DEPTH_MIN :
				((bd_reg > BIT_DEPTH_MAX) ? BIT_DEPTH_MAX : bd_reg);
			if (r.al && r.at)
				dc = (sum + 4) >> 3;
			else if (r.al || r.at)
				dc = (sum + 2) >> 2;
			else
				dc = 1 << (bd - 1);
			for (y = 0; y < 4; y++)
				for (x = 0; x < 4; x++)
					p.rows[y][x] = sample_t'(dc);
		end else begin
			for (y = 0; y < 4; y++)
				for (x = 0; x < 4; x++)
					p.rows[y][x] = sample_t'(directional_sample(r.mode, x, y));
		end
		return p;
	endfunction

	// ---------------- request generation ----------------
	function automatic sample_t random_sample();
		case ($urandom_range(9))
			0: return '0;
			1: return sample_t'(SAMPLE_MAX);
			2, 3, 4, 5: return sample_t'($urandom_range(255));
			default: return sample_t'($urandom_range(SAMPLE_MAX));
		endcase
	endfunction

	// fill < 0 gives random samples, else every sample takes the fill value
	function automatic blk_req_t build_request(input logic [3:0] mode, input logic [3:0] avail,
			input int fill);
		blk_req_t r;
		int k;
		r.mode = mode;
		for (k = 0; k < 4; k++) begin
			r.left[k] = (fill < 0) ? random_sample() : sample_t'(fill);
			r.top[k] = (fill < 0) ? random_sample() : sample_t'(fill);
			r.top_right[k] = (fill < 0) ? random_sample() : sample_t'(fill);
		end
		r.corner = (fill < 0) ? random_sample() : sample_t'(fill);
		{r.ac, r.atr, r.at, r.al} = avail;
		return r;
	endfunction

	function automatic blk_req_t random_request();
		blk_req_t r;
		logic [3:0] mode;
		mode = ($urandom_range(99) < 85) ? 4'($urandom_range(MODE_HU)) :
			4'($urandom_range(MODE_ILLEGAL_HI));
		r = build_request(mode, 4'($urandom_range(AV_ALL)), -1);
		// mostly give the mode the neighbors it needs so the filters get exercised
		if ($urandom_range(99) < 70) begin
			case (mode)
				MODE_VERT, MODE_DL, MODE_VL: r.at = 1'b1;
				MODE_HOR, MODE_HU: r.al = 1'b1;
				MODE_DR, MODE_VR, MODE_HD: begin
					r.al = 1'b1;
					r.at = 1'b1;
					r.ac = 1'b1;
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	// ---------------- bus tasks ----------------
	task automatic send_request(input blk_req_t r);
		if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < gap_pct);
		end
		s_tdata <= {2'b00, r.corner, r.top_right, r.top, r.left};
		s_tuser <= {r.ac, r.atr, r.at, r.al, r.mode};
		s_tvalid <= 1'b1;
		do
			@(negedge clk);
		while (!s_tready);
		@(posedge clk);
		pending_blocks.push_back(predict_block(r, cfg_bit_depth));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_blocks.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (pready !== 1'b1) begin
			$error("pready: expected 1, actual %b", pready);
			fail_cnt++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_BIT_DEPTH)
			cfg_bit_depth = data[3:0];
	endtask

	// ---------------- tests ----------------
	task automatic test_directed();
		int m;
		gap_pct = 0;
		stall_pct = 0;
		// mid-grey fallback at the reset bit depth
		send_request(build_request(MODE_DC, AV_NONE, -1));
		for (m = MODE_VERT; m <= MODE_HU; m++)
			send_request(build_request(4'(m), AV_ALL, -1));
		// full-scale samples stress the rounding sums, zeros the low end
		send_request(build_request(MODE_DR, AV_ALL, SAMPLE_MAX));
		send_request(build_request(MODE_HU, AV_ALL, SAMPLE_MAX));
		send_request(build_request(MODE_VR, AV_ALL, 0));
		send_request(build_request(MODE_ILLEGAL_LO, AV_ALL, -1));
		send_request(build_request(MODE_ILLEGAL_HI, AV_ALL, SAMPLE_MAX));
		send_request(build_request(MODE_VERT, AV_L | AV_TR | AV_C, -1));
		send_request(build_request(MODE_HOR, AV_T | AV_TR | AV_C, -1));
		send_request(build_request(MODE_DR, AV_L | AV_T | AV_TR, -1));
		send_request(build_request(MODE_HU, AV_T | AV_C, -1));
		send_request(build_request(MODE_VL, AV_L | AV_C, -1));
		// top-right replicated from the last top sample
		send_request(build_request(MODE_DL, AV_T, -1));
		send_request(build_request(MODE_VL, AV_T | AV_L, -1));
		send_request(build_request(MODE_DC, AV_L, -1));
		send_request(build_request(MODE_DC, AV_T | AV_TR, -1));
		// top-right flag without top is ignored
		send_request(build_request(MODE_DC, AV_L | AV_TR, -1));
	endtask

	task automatic test_bit_depth_sweep();
		int depths[6];
		int i;
		depths = '{BIT_DEPTH_MAX, 13, 0, 15, 9, BIT_DEPTH_MIN};
		gap_pct = 0;
		stall_pct = 0;
		for (i = 0; i < 6; i++) begin
			wait_idle();
			write_reg(ADDR_BIT_DEPTH, 32'(depths[i]));
			// read back through the still-addressed register
			@(posedge clk);
			if (prdata !== {28'd0, cfg_bit_depth}) begin
				$error("bit_depth: expected %0d, actual %0d", cfg_bit_depth, prdata);
				fail_cnt++;
			end
			send_request(build_request(MODE_DC, AV_NONE, -1));
			send_request(build_request(MODE_DC, AV_TR | AV_C, -1));
		end
	endtask

	task automatic test_random_phase(input int gap, input int stall, input int count,
			input logic [3:0] depth);
		int i;
		wait_idle();
		write_reg(ADDR_BIT_DEPTH, 32'(depth));
		gap_pct = gap;
		stall_pct = stall;
		for (i = 0; i < count; i++)
			send_request(random_request());
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_bit_depth_sweep();
		test_random_phase(0, 0, 240, BIT_DEPTH_MIN);
		test_random_phase(84, 0, 240, BIT_DEPTH_MAX);
		test_random_phase(0, 84, 240, 4'($urandom_range(BIT_DEPTH_MIN, BIT_DEPTH_MAX)));
		test_random_phase(23, 23, 240, 4'($urandom_range(15)));
		wait_idle();
		if (fail_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// ---------------- result side ----------------
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	// handshakes are sampled mid-cycle; they complete at the following rising edge
	always @(negedge clk) begin
		block_pred_t want;
		int r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_blocks.size() == 0) begin
				$error("result with no request pending: status %0d", m_tuser);
				fail_cnt++;
			end else begin
				want = pending_blocks.pop_front();
				for (r = 0; r < 4; r++) begin
					if (m_tdata[56*r +: 56] !== want.rows[r]) begin
						$error("row_%0d: expected %h, actual %h", r, want.rows[r],
							m_tdata[56*r +: 56]);
						fail_cnt++;
					end
				end
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_tuser);
					fail_cnt++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule
